// ----- rtl/prdd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_pkg
// Shared types and constants of the planar run-length / delta decoder.
// ----------------------------------------------------------------------------
package prdd_pkg;

  localparam int unsigned RecordBitsDefault    = 24;
  localparam int unsigned MaxValueBytesDefault = 4;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 24;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_PLANE_TOTAL  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_RECORD_TOTAL = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_WIDE_SAMPLES = 2'd2;

  // Error codes of a result.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MODE   = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;
  localparam logic [1:0] ERR_TRUNC  = 2'd3;

  localparam logic [7:0] LEN_MASK  = 8'h7F;
  localparam logic [7:0] RUN_BIT   = 8'h80;
  localparam logic [7:0] MODE_MAX  = 8'd3;

  typedef struct packed {
    logic [7:0]  plane_total;
    logic [23:0] record_total;
    logic        wide_samples;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] first_value;
    logic [31:0] step_value;
    logic [6:0]  value_count;
    logic [23:0] record_index;
    logic [7:0]  plane_index;
    logic        pool_done;
    logic [1:0]  error_code;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/prdd_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_in_if
// Byte channel into the decoder.
// ----------------------------------------------------------------------------
interface prdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/prdd_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_out_if
// Descriptor channel out of the decoder.
// ----------------------------------------------------------------------------
interface prdd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_value;
  logic [31:0] step_value;
  logic [6:0]  value_count;
  logic [23:0] record_index;
  logic [7:0]  plane_index;
  logic        pool_done;
  logic [1:0]  error_code;

  modport source (output valid, output first_value, output step_value, output value_count,
                  output record_index, output plane_index, output pool_done,
                  output error_code, input ready);
  modport sink (input valid, input first_value, input step_value, input value_count,
                input record_index, input plane_index, input pool_done,
                input error_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/prdd_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface prdd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [23:0] write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/prdd_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_cfg_regs
// Decodes configuration writes into the decoder's registers.
// ----------------------------------------------------------------------------
module prdd_cfg_regs (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    wr_valid_i,
  input  logic [prdd_pkg::CfgIndexWidth-1:0]      wr_index_i,
  input  logic [prdd_pkg::CfgDataWidth-1:0]       wr_data_i,
  output prdd_pkg::cfg_t                          cfg_o
);
  import prdd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        CFG_PLANE_TOTAL:  cfg_d.plane_total  = wr_data_i[7:0];
        CFG_RECORD_TOTAL: cfg_d.record_total = wr_data_i;
        CFG_WIDE_SAMPLES: cfg_d.wide_samples = wr_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_total  <= 8'd1;
      cfg_q.record_total <= '0;
      cfg_q.wide_samples <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/prdd_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_in_stage
// Input register holding one byte item for the decode step.
// ----------------------------------------------------------------------------
module prdd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  prdd_pkg::item_t in_item_i,
  output logic            in_ready_o,
  output logic            item_valid_o,
  output prdd_pkg::item_t item_o,
  input  logic            advance_i
);
  import prdd_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// ----- rtl/prdd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_core
// Decode state and the combinational step that consumes one body byte.
// ----------------------------------------------------------------------------
module prdd_core #(
  parameter int unsigned RECORD_BITS     = prdd_pkg::RecordBitsDefault,
  parameter int unsigned MAX_VALUE_BYTES = prdd_pkg::MaxValueBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prdd_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  prdd_pkg::item_t   item_i,
  output logic              res_valid_o,
  output prdd_pkg::result_t res_o
);
  import prdd_pkg::*;

  localparam int unsigned RB = RECORD_BITS;
  localparam int unsigned VW = 8 * MAX_VALUE_BYTES;

  typedef enum logic [1:0] {PH_MODE, PH_CODE, PH_VALUE} phase_e;
  typedef enum logic [1:0] {H_RUN, H_PENDING, H_DONE, H_ERROR} halt_e;

  phase_e        phase_q, phase_d;
  halt_e         halted_q, halted_d;
  logic [7:0]    plane_q, plane_d;
  logic [RB-1:0] rec_q, rec_d;
  logic [VW-1:0] sum_q, sum_d;
  logic [VW-1:0] shift_q, shift_d;
  logic [1:0]    bpos_q, bpos_d;
  logic [6:0]    group_q, group_d;
  logic [1:0]    mode_q, mode_d;
  logic          run_q, run_d;
  logic [8:0]    deficit_q, deficit_d;

  logic [RB-1:0] total;
  logic [RB-1:0] left;
  logic [7:0]    plane_limit;
  logic [7:0]    plane_inc;
  logic [VW-1:0] vmask;
  logic [2:0]    nbytes;
  logic [2:0]    bpos_inc;
  logic [8:0]    deficit_dec;
  logic [8:0]    need;
  logic [6:0]    len;
  logic [6:0]    cnt;
  logic [6:0]    group_next;
  logic [VW-1:0] shift_new;
  logic [VW-1:0] val;
  logic [VW-1:0] prod;
  logic          plane_end;
  logic          mode_end;
  logic          done_now;
  logic          res_valid;
  result_t       res;

  always_comb begin
    total       = RB'(cfg_i.record_total);
    plane_limit = (cfg_i.plane_total == 8'd0) ? 8'd1 : cfg_i.plane_total;
    vmask       = cfg_i.wide_samples ? {VW{1'b1}} : VW'(16'hFFFF);
    nbytes      = cfg_i.wide_samples ? 3'(MAX_VALUE_BYTES) : 3'd2;
    deficit_dec = (deficit_q != 9'd0) ? deficit_q - 9'd1 : deficit_q;
    len         = item_i.data_byte[6:0] & LEN_MASK[6:0];
    left        = total - rec_q;
    need        = '0;
    cnt         = '0;
    group_next  = '0;
    val         = '0;
    prod        = '0;
    bpos_inc    = {1'b0, bpos_q} + 3'd1;
    plane_inc   = plane_q + 8'd1;
    shift_new   = shift_q;
    for (int j = 0; j < MAX_VALUE_BYTES; j++) begin
      if (bpos_q == 2'(j)) begin
        shift_new[8*j +: 8] = item_i.data_byte;
      end
    end

    phase_d   = phase_q;
    halted_d  = halted_q;
    plane_d   = plane_q;
    rec_d     = rec_q;
    sum_d     = sum_q;
    shift_d   = shift_q;
    bpos_d    = bpos_q;
    group_d   = group_q;
    mode_d    = mode_q;
    run_d     = run_q;
    deficit_d = deficit_dec;
    plane_end = 1'b0;
    mode_end  = 1'b0;
    done_now  = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (halted_q == H_PENDING) begin
      if (deficit_dec == 9'd0) begin
        halted_d      = H_DONE;
        res_valid     = 1'b1;
        res.pool_done = 1'b1;
      end
    end else if (halted_q == H_RUN) begin
      unique case (phase_q)
        PH_MODE: begin
          if (item_i.data_byte > MODE_MAX) begin
            halted_d         = H_ERROR;
            res_valid        = 1'b1;
            res.record_index = 24'(rec_q);
            res.plane_index  = plane_q;
            res.error_code   = ERR_MODE;
          end else begin
            mode_d  = item_i.data_byte[1:0];
            rec_d   = '0;
            sum_d   = '0;
            shift_d = '0;
            bpos_d  = '0;
            if (total == '0) begin
              plane_end = 1'b1;
              mode_end  = 1'b1;
            end else if (item_i.data_byte[1]) begin
              phase_d = PH_CODE;
            end else begin
              phase_d = PH_VALUE;
              run_d   = 1'b0;
              group_d = '0;
            end
          end
        end
        PH_CODE: begin
          if (len == 7'd0) begin
            halted_d         = H_ERROR;
            res_valid        = 1'b1;
            res.record_index = 24'(rec_q);
            res.plane_index  = plane_q;
            res.error_code   = ERR_LENGTH;
          end else begin
            run_d   = (item_i.data_byte & RUN_BIT) != 8'd0;
            group_d = (RB'(len) < left) ? len : left[6:0];
            need    = run_d ? 9'(nbytes) : 9'(len) * 9'(nbytes);
            if (need > deficit_dec) begin
              deficit_d = need;
            end
            shift_d = '0;
            bpos_d  = '0;
            phase_d = PH_VALUE;
          end
        end
        default: begin
          if (bpos_inc >= nbytes) begin
            val  = shift_new & vmask;
            cnt  = run_q ? group_q : 7'd1;
            prod = val * VW'(cnt);
            res_valid        = 1'b1;
            res.value_count  = cnt;
            res.record_index = 24'(rec_q);
            res.plane_index  = plane_q;
            if (mode_q[0]) begin
              res.first_value = 32'((sum_q + val) & vmask);
              res.step_value  = 32'(val);
              sum_d           = (sum_q + prod) & vmask;
            end else begin
              res.first_value = 32'(val);
            end
            rec_d   = rec_q + RB'(cnt);
            shift_d = '0;
            bpos_d  = '0;
            if (mode_q[1]) begin
              group_next = run_q ? 7'd0 : group_q - 7'd1;
              group_d    = group_next;
              if (group_next == 7'd0) begin
                phase_d = PH_CODE;
              end
            end
            if (rec_d >= total) begin
              plane_end = 1'b1;
            end
          end else begin
            shift_d = shift_new;
            bpos_d  = bpos_inc[1:0];
          end
        end
      endcase

      if (plane_end) begin
        plane_d = plane_inc;
        rec_d   = '0;
        sum_d   = '0;
        phase_d = PH_MODE;
        if (plane_inc >= plane_limit) begin
          if (deficit_dec == 9'd0) begin
            halted_d = H_DONE;
            done_now = 1'b1;
          end else begin
            halted_d = H_PENDING;
          end
        end
      end
      if (mode_end) begin
        res_valid = done_now;
      end
      res.pool_done = done_now;
    end

    if (item_i.final_byte) begin
      if (halted_d == H_RUN || halted_d == H_PENDING) begin
        if (res_valid) begin
          res.pool_done  = 1'b0;
          res.error_code = ERR_TRUNC;
        end else begin
          res              = '0;
          res_valid        = 1'b1;
          res.record_index = (halted_d == H_RUN) ? 24'(rec_d) : 24'd0;
          res.plane_index  = (halted_d == H_RUN) ? plane_d : 8'd0;
          res.error_code   = ERR_TRUNC;
        end
      end
      phase_d   = PH_MODE;
      halted_d  = H_RUN;
      plane_d   = '0;
      rec_d     = '0;
      sum_d     = '0;
      shift_d   = '0;
      bpos_d    = '0;
      group_d   = '0;
      mode_d    = '0;
      run_d     = 1'b0;
      deficit_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MODE;
      halted_q  <= H_RUN;
      plane_q   <= '0;
      rec_q     <= '0;
      sum_q     <= '0;
      shift_q   <= '0;
      bpos_q    <= '0;
      group_q   <= '0;
      mode_q    <= '0;
      run_q     <= 1'b0;
      deficit_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      halted_q  <= halted_d;
      plane_q   <= plane_d;
      rec_q     <= rec_d;
      sum_q     <= sum_d;
      shift_q   <= shift_d;
      bpos_q    <= bpos_d;
      group_q   <= group_d;
      mode_q    <= mode_d;
      run_q     <= run_d;
      deficit_q <= deficit_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule
`default_nettype wire

// ----- rtl/prdd_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prdd_out_stage
// Result register that holds a descriptor until the sink takes it.
// ----------------------------------------------------------------------------
module prdd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  prdd_pkg::result_t res_i,
  output logic              can_take_o,
  output logic              out_valid_o,
  output prdd_pkg::result_t out_res_o,
  input  logic              out_ready_i
);
  import prdd_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule
`default_nettype wire

// ----- rtl/planar_rle_delta_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// planar_rle_delta_decoder
// Decodes a planar point-pool body, one byte per item, into run and value
// descriptors with delta accumulation and status reports.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  in_ch    in   valid/ready   data_byte, final_byte
//  out_ch   out  valid/ready   first_value .. error_code (one descriptor)
//  cfg_ch   in   valid/ready   reg_index, write_data (always ready)
//
// One byte item is taken per cycle while the result register can take a
// result; an accepted item waits in the input register, and any result of
// it is loaded into the result register when the decode step advances. The
// two registers stand around the combinational decode step.
// The input side keeps flowing while a result waits, until both registers
// hold an item. Reset clears all decode state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module planar_rle_delta_decoder #(
  parameter int unsigned RECORD_BITS     = prdd_pkg::RecordBitsDefault,
  parameter int unsigned MAX_VALUE_BYTES = prdd_pkg::MaxValueBytesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  prdd_in_if.sink    in_ch,
  prdd_out_if.source out_ch,
  prdd_cfg_if.sink   cfg_ch
);
  import prdd_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    can_take;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ch.ready = 1'b1;

  prdd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_ch.valid),
    .wr_index_i (cfg_ch.reg_index),
    .wr_data_i  (cfg_ch.write_data),
    .cfg_o      (cfg)
  );

  assign in_item.data_byte  = in_ch.data_byte;
  assign in_item.final_byte = in_ch.final_byte;

  prdd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_ch.ready),
    .item_valid_o (item_valid),
    .item_o       (item),
    .advance_i    (step)
  );

  assign step = item_valid && can_take;

  prdd_core #(
    .RECORD_BITS     (RECORD_BITS),
    .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  prdd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_valid_o (out_ch.valid),
    .out_res_o   (out_res),
    .out_ready_i (out_ch.ready)
  );

  assign out_ch.first_value  = out_res.first_value;
  assign out_ch.step_value   = out_res.step_value;
  assign out_ch.value_count  = out_res.value_count;
  assign out_ch.record_index = out_res.record_index;
  assign out_ch.plane_index  = out_res.plane_index;
  assign out_ch.pool_done    = out_res.pool_done;
  assign out_ch.error_code   = out_res.error_code;

endmodule
`default_nettype wire
